>>> rtl/likelihood_cross_match_unit_defines.svh
// likelihood_cross_match_unit_defines.svh: assertion macros for the cross match unit
// depends on nothing; the modules that use it declare clk and rst
`ifndef LIKELIHOOD_CROSS_MATCH_UNIT_DEFINES_SVH
`define LIKELIHOOD_CROSS_MATCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, off while reset is high
`define LCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcm check failed");
// checked property, also during reset
`define LCM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lcm check failed");
`else
`define LCM_ASSERT(lbl, prop)
`define LCM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/lcm_pkg.sv
// lcm_pkg: shared types, codes and constants of the cross match unit
// depends on nothing
`timescale 1ns / 1ps
package lcm_pkg;
  localparam int MAX_REF_DEF = 1024;
  localparam int MAX_COM_DEF = 1024;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_MATCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // config register indexes
  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_SWAP     = 3'd1;
  localparam logic [2:0] REG_COM_ERR  = 3'd2;
  localparam logic [2:0] REG_REF_ERR  = 3'd3;
  localparam logic [2:0] REG_COM_RANK = 3'd4;
  localparam logic [2:0] REG_REF_RANK = 3'd5;

  localparam logic [30:0] RADIUS_RESET = 31'd4096;

  // divider widths: dist^2, variance, capped quotient
  localparam int DIVD_W = 63;
  localparam int DIVS_W = 33;
  localparam int QUO_W  = 41;

  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [30:0] radius;
    logic        swap_axes;
    logic        use_com_err;
    logic        use_ref_err;
    logic        use_com_rank;
    logic        use_ref_rank;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] rank;
    logic [15:0]        err;
    logic [9:0]         obj;
  } item_t;
endpackage

>>> rtl/likelihood_cross_match_unit.sv
// likelihood_cross_match_unit: positional cross match with likelihood score, top level
// depends on lcm_pkg, lcm_front and lcm_engine
//
// Input channel: push/full. Each word carries command (load reference,
// match object, clear table), position, log rank, error and object number.
// Result channel: empty/pop. Every match of an object number below MAX_COM
// gives one result word; loads, clears and unknown commands give none.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write it only while the block is idle.
// Timing: a load or clear is done by the engine without leaving its idle state.
// A match runs a binary search (about log2 of the loaded count probes), walks
// the window entries and scores the entries inside the radius; the 41 step
// divider computing each candidate's score sets the bulk of it.
// A two word queue in front takes new words while the engine works, and the
// result register holds a finished word while the next match runs up to its
// last step; a stalled receiver holds the engine only at that step.
// Reset empties the table and the queues and loads the register defaults
// (radius 1.0, all options off). No memory clearing pass is needed.
`timescale 1ns / 1ps
module likelihood_cross_match_unit #(
  parameter int MAX_REF = lcm_pkg::MAX_REF_DEF,
  parameter int MAX_COM = lcm_pkg::MAX_COM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] log_rank,
  input  logic [15:0]        pos_err,
  input  logic [9:0]         obj_index,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         com_index,
  output logic               matched,
  output logic [9:0]         ref_index,
  output logic signed [31:0] best_score,
  output logic               displaced,
  output logic [9:0]         displaced_com,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import lcm_pkg::*;

  cfg_t  cfg;
  item_t in_item, item;
  logic  item_valid, item_take, out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;
  assign in_item   = '{cmd: command, pos_x: pos_x, pos_y: pos_y, rank: log_rank,
                       err: pos_err, obj: obj_index};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{radius: RADIUS_RESET, default: 1'b0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS:   cfg.radius       <= cfg_data[30:0];
        REG_SWAP:     cfg.swap_axes    <= cfg_data[0];
        REG_COM_ERR:  cfg.use_com_err  <= cfg_data[0];
        REG_REF_ERR:  cfg.use_ref_err  <= cfg_data[0];
        REG_COM_RANK: cfg.use_com_rank <= cfg_data[0];
        REG_REF_RANK: cfg.use_ref_rank <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lcm_front #(.MAX_COM(MAX_COM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  lcm_engine #(.MAX_REF(MAX_REF)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .out_valid   (out_valid),
    .out_pop     (pop),
    .out_com     (com_index),
    .out_matched (matched),
    .out_ref     (ref_index),
    .out_score   (best_score),
    .out_disp    (displaced),
    .out_dcom    (displaced_com)
  );
endmodule

>>> rtl/lcm_front.sv
// lcm_front: accepts command words, drops those without effect, queues the rest
// depends on lcm_pkg
`timescale 1ns / 1ps
module lcm_front #(
  parameter int MAX_COM = lcm_pkg::MAX_COM_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  lcm_pkg::item_t in_item,
  output logic          item_valid,
  output lcm_pkg::item_t item,
  input  logic          item_take
);
  import lcm_pkg::*;

  item_t      q [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       keep, wr, rd;

  // classify: unknown command and out of range objects leave no trace
  always_comb begin
    case (in_item.cmd)
      CMD_LOAD, CMD_CLEAR: keep = 1'b1;
      CMD_MATCH:           keep = (32'(in_item.obj) < MAX_COM);
      default:             keep = 1'b0;
    endcase
  end

  assign full       = (cnt == 2'd2);
  assign wr         = push && !full && keep;
  assign item_valid = (cnt != 2'd0);
  assign rd         = item_take && item_valid;
  assign item       = q[rptr];

  // two entry queue towards the engine
  always_ff @(posedge clk) begin
    if (wr) q[wptr] <= in_item;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> rtl/lcm_div.sv
// lcm_div: restoring divider, one quotient bit per cycle, floor(dividend*128/divisor)
// depends on lcm_pkg; caller guarantees the quotient stays below 2^41
`timescale 1ns / 1ps
module lcm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lcm_pkg::DIVD_W-1:0] dividend,
  input  logic [lcm_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [lcm_pkg::QUO_W-1:0]  quo
);
  import lcm_pkg::*;

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [QUO_W-1:0]  bits;
  logic [5:0]        cnt;
  logic              busy;
  logic [DIVS_W:0]   trial;
  logic              ge;

  // one trial subtract per cycle
  assign trial = {rem, bits[QUO_W-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DIVS_W'(dividend[DIVD_W-1:QUO_W-7]);
      bits <= {dividend[QUO_W-8:0], 7'b0};
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= ge ? DIVS_W'(trial - {1'b0, dsr}) : trial[DIVS_W-1:0];
      bits <= {bits[QUO_W-2:0], 1'b0};
      quo  <= {quo[QUO_W-2:0], ge};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/lcm_engine.sv
// lcm_engine: reference table, binary search, window walk, scoring and ownership
// depends on lcm_pkg, lcm_div and likelihood_cross_match_unit_defines.svh
`timescale 1ns / 1ps
`include "likelihood_cross_match_unit_defines.svh"
module lcm_engine #(
  parameter int MAX_REF = lcm_pkg::MAX_REF_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lcm_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  lcm_pkg::item_t     item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_pop,
  output logic [9:0]         out_com,
  output logic               out_matched,
  output logic [9:0]         out_ref,
  output logic signed [31:0] out_score,
  output logic               out_disp,
  output logic [9:0]         out_dcom
);
  import lcm_pkg::*;

  localparam int RIW = $clog2(MAX_REF);
  localparam int CW  = $clog2(MAX_REF + 1);
  localparam int AW  = CW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_WRD  = 4'd3;
  localparam logic [3:0] S_WCHK = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_RANK = 4'd8;
  localparam logic [3:0] S_CAND = 4'd9;
  localparam logic [3:0] S_OWRD = 4'd10;
  localparam logic [3:0] S_OCHK = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // reference word: primary, secondary, rank, error
  logic [95:0] refmem [MAX_REF];
  // owner word: valid, object, score
  logic [42:0] ownmem [MAX_REF];

  logic [3:0]         state;
  logic [CW-1:0]      count;
  logic [95:0]        rdata;
  logic [42:0]        odata;
  logic [RIW-1:0]     rd_addr;
  logic [AW-1:0]      a, b, mid, i;
  logic signed [32:0] cp, cs, lo, hi;
  logic [61:0]        rr2;
  logic [9:0]         obj;
  logic signed [15:0] crank, rrank;
  logic [15:0]        cerr, rerr;
  logic [30:0]        da, db;
  logic [61:0]        sqa, sqb;
  logic [31:0]        ce2, re2;
  logic [40:0]        half;
  logic signed [31:0] score, best_s;
  logic [RIW-1:0]     best;
  logic               found;
  logic               div_start, div_done;
  logic [40:0]        div_q;
  logic [9:0]         r_com, r_ref, r_dcom;
  logic               r_matched, r_disp;
  logic signed [31:0] r_score;

  // combinational helpers for the compare steps
  logic signed [31:0] prim, sec;
  logic signed [32:0] dpa, dpb;
  logic [32:0]        aba, abb;
  logic [62:0]        dsum;
  logic [32:0]        vnext;
  logic signed [42:0] ssum;
  logic signed [31:0] ownsc;

  assign prim  = rdata[95:64];
  assign sec   = rdata[63:32];
  assign dpa   = cp - {prim[31], prim};
  assign dpb   = cs - {sec[31], sec};
  assign aba   = dpa[32] ? 33'(-dpa) : 33'(dpa);
  assign abb   = dpb[32] ? 33'(-dpb) : 33'(dpb);
  assign dsum  = {1'b0, sqa} + {1'b0, sqb};
  assign vnext = (cfg.use_com_err || cfg.use_ref_err)
               ? ((cfg.use_com_err ? {1'b0, ce2} : 33'd0)
                 + (cfg.use_ref_err ? {1'b0, re2} : 33'd0))
               : 33'd65536;
  assign ssum  = $signed({2'b0, half})
               + (cfg.use_com_rank ? {{19{crank[15]}}, crank, 8'b0} : 43'sd0)
               + (cfg.use_ref_rank ? {{19{rrank[15]}}, rrank, 8'b0} : 43'sd0);
  assign ownsc = odata[31:0];

  assign item_take = (state == S_IDLE) && item_valid;
  assign div_start = (state == S_SUM) && (dsum < {1'b0, rr2}) && (vnext != 33'd0)
                   && ({4'b0, dsum[62:34]} < vnext);

  // table read address
  always_comb begin
    case (state)
      S_SRCH:  rd_addr = RIW'(mid - AW'(1));
      S_WRD:   rd_addr = RIW'(i - AW'(1));
      default: rd_addr = '0;
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    rdata <= refmem[rd_addr];
    odata <= ownmem[best];
    if (item_take && item.cmd == CMD_LOAD && 32'(count) < MAX_REF) begin
      refmem[RIW'(count)] <= {cfg.swap_axes ? item.pos_y : item.pos_x,
                              cfg.swap_axes ? item.pos_x : item.pos_y,
                              item.rank, item.err};
      ownmem[RIW'(count)] <= '0;
    end else if (state == S_OCHK && !(odata[42] && best_s > ownsc)) begin
      ownmem[best] <= {1'b1, obj, best_s};
    end
  end

  // divider loads dist^2 and variance at the start pulse
  lcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dsum),
    .divisor  (vnext),
    .done     (div_done),
    .quo      (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && out_pop && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (item.cmd)
              CMD_LOAD: if (32'(count) < MAX_REF) count <= count + CW'(1);
              CMD_CLEAR: count <= '0;
              default: begin
                obj   <= item.obj;
                crank <= item.rank;
                cerr  <= item.err;
                cp    <= cfg.swap_axes ? 33'(item.pos_y) : 33'(item.pos_x);
                cs    <= cfg.swap_axes ? 33'(item.pos_x) : 33'(item.pos_y);
                lo    <= (cfg.swap_axes ? 33'(item.pos_y) : 33'(item.pos_x))
                       - $signed({2'b0, cfg.radius});
                hi    <= (cfg.swap_axes ? 33'(item.pos_y) : 33'(item.pos_x))
                       + $signed({2'b0, cfg.radius});
                rr2   <= cfg.radius * cfg.radius;
                a     <= AW'(1);
                b     <= AW'(count);
                mid   <= AW'((AW'(1) + AW'(count)) >> 1);
                found <= 1'b0;
                state <= S_SRCH;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (b >= a + AW'(2) && mid != '0 && mid <= AW'(count)) begin
            state <= S_SCMP;
          end else begin
            i     <= a;
            state <= S_WRD;
          end
        end
        S_SCMP: begin
          if ($signed({prim[31], prim}) < lo) begin
            a     <= mid;
            mid   <= (mid + b) >> 1;
            state <= S_SRCH;
          end else if ($signed({prim[31], prim}) > lo) begin
            b     <= mid;
            mid   <= (mid + a) >> 1;
            state <= S_SRCH;
          end else begin
            i     <= mid;
            state <= S_WRD;
          end
        end
        S_WRD: begin
          if (i >= AW'(1) && i <= AW'(count)) state <= S_WCHK;
          else state <= S_OWRD;
        end
        S_WCHK: begin
          if ($signed({prim[31], prim}) > hi) begin
            state <= S_OWRD;
          end else if (cfg.radius == '0 || aba >= {2'b0, cfg.radius}
                       || abb >= {2'b0, cfg.radius}) begin
            i     <= i + AW'(1);
            state <= S_WRD;
          end else begin
            da    <= aba[30:0];
            db    <= abb[30:0];
            rrank <= rdata[31:16];
            rerr  <= rdata[15:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          sqa   <= da * da;
          sqb   <= db * db;
          ce2   <= cerr * cerr;
          re2   <= rerr * rerr;
          state <= S_SUM;
        end
        S_SUM: begin
          if (dsum >= {1'b0, rr2}) begin
            i     <= i + AW'(1);
            state <= S_WRD;
          end else if (vnext == 33'd0) begin
            score <= SCORE_MAX;
            state <= S_CAND;
          end else if (!div_start) begin
            half  <= 41'h100_0000_0000;
            state <= S_RANK;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            half  <= div_q[40] ? 41'h100_0000_0000 : div_q;
            state <= S_RANK;
          end
        end
        S_RANK: begin
          if (ssum > 43'(SCORE_MAX)) score <= SCORE_MAX;
          else if (ssum < 43'(SCORE_MIN)) score <= SCORE_MIN;
          else score <= ssum[31:0];
          state <= S_CAND;
        end
        S_CAND: begin
          if (!found || score < best_s) begin
            found  <= 1'b1;
            best   <= RIW'(i - AW'(1));
            best_s <= score;
          end
          i     <= i + AW'(1);
          state <= S_WRD;
        end
        S_OWRD: begin
          r_com     <= obj;
          r_matched <= 1'b0;
          r_ref     <= '0;
          r_score   <= '0;
          r_disp    <= 1'b0;
          r_dcom    <= '0;
          state     <= found ? S_OCHK : S_OUT;
        end
        S_OCHK: begin
          if (!(odata[42] && best_s > ownsc)) begin
            r_matched <= 1'b1;
            r_ref     <= 10'(best);
            r_score   <= best_s;
            r_disp    <= odata[42];
            r_dcom    <= odata[42] ? odata[41:32] : 10'd0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_pop) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_pop)) begin
      out_com     <= r_com;
      out_matched <= r_matched;
      out_ref     <= r_ref;
      out_score   <= r_score;
      out_disp    <= r_disp;
      out_dcom    <= r_dcom;
    end
  end

  `LCM_ASSERT(a_count_range, 32'(count) <= MAX_REF)
  `LCM_ASSERT(a_div_only_in_sum, div_start |-> state == S_SUM)
  `LCM_ASSERT(a_div_done_leaves, (state == S_DIV && div_done) |=> state == S_RANK)
  `LCM_ASSERT(a_walk_in_table,
              state == S_WCHK |-> (i >= AW'(1) && i <= AW'(count)))
  `LCM_ASSERT(a_owner_needs_winner, state == S_OCHK |-> found)
endmodule

>>> test/tb.sv
// tb: self-checking bench for likelihood_cross_match_unit, random and directed words
// depends on lcm_pkg and the rtl; a scoreboard class predicts every match result
`timescale 1ns / 1ps
module tb;
  import lcm_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint CAP40 = 64'd1 << 40;
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [9:0]         com;
    logic               hit;
    logic [9:0]         ref_no;
    logic signed [31:0] score;
    logic               disp;
    logic [9:0]         disp_com;
  } match_res_t;

  // predicts the match results from the loaded table and owners
  class match_scoreboard;
    cfg_t               cfg;
    logic signed [31:0] prim [TABLE_DEPTH];
    logic signed [31:0] sec [TABLE_DEPTH];
    logic signed [15:0] rrank [TABLE_DEPTH];
    logic [15:0]        rerr [TABLE_DEPTH];
    logic               own_valid [TABLE_DEPTH];
    logic [9:0]         own_com [TABLE_DEPTH];
    logic signed [31:0] own_score [TABLE_DEPTH];
    int                 count;
    match_res_t         pending [$];
    int                 errors;

    function new();
      cfg = '0;
      cfg.radius = RADIUS_RESET;
      count = 0;
      errors = 0;
      foreach (own_valid[i]) own_valid[i] = 1'b0;
    endfunction

    function void note_config(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_RADIUS:   cfg.radius = data[30:0];
        REG_SWAP:     cfg.swap_axes = data[0];
        REG_COM_ERR:  cfg.use_com_err = data[0];
        REG_REF_ERR:  cfg.use_ref_err = data[0];
        REG_COM_RANK: cfg.use_com_rank = data[0];
        REG_REF_RANK: cfg.use_ref_rank = data[0];
        default: ;
      endcase
    endfunction

    // half of dist^2 over variance plus enabled ranks, saturated
    function logic signed [31:0] likelihood(longint unsigned d, logic [15:0] ce,
                                            logic [15:0] re, logic signed [15:0] cr,
                                            logic signed [15:0] rk);
      longint unsigned v, q, rem;
      longint          half, s;
      v = 0;
      if (cfg.use_com_err) v += longint'(ce) * longint'(ce);
      if (cfg.use_ref_err) v += longint'(re) * longint'(re);
      if (!cfg.use_com_err && !cfg.use_ref_err) v = 65536;
      if (v == 0) return SCORE_MAX;
      q = d / v;
      rem = d % v;
      if (q >= CAP40) half = CAP40;
      else half = q * 128 + (rem * 128) / v;
      if (half > CAP40) half = CAP40;
      s = half;
      if (cfg.use_com_rank) s += longint'(cr) * 256;
      if (cfg.use_ref_rank) s += longint'(rk) * 256;
      if (s > longint'(SCORE_MAX)) s = SCORE_MAX;
      if (s < longint'(SCORE_MIN)) s = SCORE_MIN;
      return s[31:0];
    endfunction

    function void note_input(item_t it);
      longint             cp, cs, r, lo, hi, pv, diff;
      longint unsigned    da, db, d;
      int                 a, b, mid, best;
      bit                 found;
      logic signed [31:0] best_s, s;
      match_res_t         res;
      found = 0;
      best = 0;
      best_s = 0;
      res = '0;
      case (it.cmd)
        CMD_LOAD: begin
          if (count < TABLE_DEPTH) begin
            prim[count] = cfg.swap_axes ? it.pos_y : it.pos_x;
            sec[count] = cfg.swap_axes ? it.pos_x : it.pos_y;
            rrank[count] = it.rank;
            rerr[count] = it.err;
            own_valid[count] = 1'b0;
            count++;
          end
        end
        CMD_CLEAR: begin
          count = 0;
          foreach (own_valid[i]) own_valid[i] = 1'b0;
        end
        CMD_MATCH: begin
          cp = cfg.swap_axes ? it.pos_y : it.pos_x;
          cs = cfg.swap_axes ? it.pos_x : it.pos_y;
          r = longint'(cfg.radius);
          lo = cp - r;
          hi = cp + r;
          // binary search over 1-based entries for the window start
          a = 1;
          b = count;
          mid = (a + b) / 2;
          while (b >= a + 2) begin
            if (mid == 0 || mid > count) break;
            pv = prim[mid - 1];
            if (pv < lo) begin
              a = mid;
              mid = (mid + b) / 2;
            end else if (pv > lo) begin
              b = mid;
              mid = (mid + a) / 2;
            end else begin
              a = mid;
              break;
            end
          end
          // walk the window
          for (int i = a; i >= 1 && i <= count; i++) begin
            pv = prim[i - 1];
            if (pv > hi) break;
            diff = cp - pv;
            da = diff < 0 ? -diff : diff;
            diff = cs - longint'(sec[i - 1]);
            db = diff < 0 ? -diff : diff;
            if (r == 0 || da >= r || db >= r) continue;
            d = da * da + db * db;
            if (d >= r * r) continue;
            s = likelihood(d, it.err, rerr[i - 1], it.rank, rrank[i - 1]);
            if (!found || s < best_s) begin
              found = 1;
              best = i - 1;
              best_s = s;
            end
          end
          res.com = it.obj;
          if (found && !(own_valid[best] && best_s > own_score[best])) begin
            res.hit = 1'b1;
            res.ref_no = best[9:0];
            res.score = best_s;
            res.disp = own_valid[best];
            res.disp_com = own_valid[best] ? own_com[best] : 10'd0;
            own_valid[best] = 1'b1;
            own_com[best] = it.obj;
            own_score[best] = best_s;
          end
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(match_res_t got);
      match_res_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected, com_index %0d", got.com);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.com !== want.com) begin
        $error("com_index expected %0d got %0d", want.com, got.com);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("matched expected %0d got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.ref_no !== want.ref_no) begin
        $error("ref_index expected %0d got %0d", want.ref_no, got.ref_no);
        errors++;
      end
      if (got.score !== want.score) begin
        $error("best_score expected %0d got %0d", want.score, got.score);
        errors++;
      end
      if (got.disp !== want.disp) begin
        $error("displaced expected %0d got %0d", want.disp, got.disp);
        errors++;
      end
      if (got.disp_com !== want.disp_com) begin
        $error("displaced_com expected %0d got %0d", want.disp_com, got.disp_com);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         command = CMD_LOAD;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [15:0] log_rank = '0;
  logic [15:0]        pos_err = '0;
  logic [9:0]         obj_index = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [9:0]         com_index;
  logic               matched;
  logic [9:0]         ref_index;
  logic signed [31:0] best_score;
  logic               displaced;
  logic [9:0]         displaced_com;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  match_scoreboard sb = new();
  int              hold_left = 0;
  int              words_sent = 0;
  longint          cycles = 0;
  int              ref_x [$];
  int              ref_y [$];

  likelihood_cross_match_unit dut (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: check accepted words, random stalls and the long hold-off
  initial begin
    int stall;
    int roll;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        sb.check_result({com_index, matched, ref_index, best_score, displaced, displaced_com});
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 12) stall = $urandom_range(1, 3);
        else if (roll < 14) stall = $urandom_range(10, 60);
      end
    end
  end

  // offer one word until taken, then maybe a gap
  task automatic send_word(logic [1:0] c, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [15:0] rk, logic [15:0] e, logic [9:0] o);
    item_t it;
    int    roll, gap;
    push <= 1'b1;
    command <= c;
    pos_x <= x;
    pos_y <= y;
    log_rank <= rk;
    pos_err <= e;
    obj_index <= o;
    @(posedge clk);
    while (full) @(posedge clk);
    it.cmd = c;
    it.pos_x = x;
    it.pos_y = y;
    it.rank = rk;
    it.err = e;
    it.obj = o;
    sb.note_input(it);
    if (c != CMD_BAD) words_sent++;
    if (c == CMD_LOAD) begin
      ref_x.push_back(x);
      ref_y.push_back(y);
    end
    if (c == CMD_CLEAR) begin
      ref_x.delete();
      ref_y.delete();
    end
    roll = $urandom_range(0, 99);
    gap = roll < 65 ? 0 : roll < 93 ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write once every result is in and the engine is done
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    int          roll;
    logic [31:0] rad;
    roll = $urandom_range(0, 9);
    case (roll)
      0: rad = 0;
      1: rad = 1;
      2: rad = 32'h7FFF_FFFF;
      3, 4: rad = 4096;
      5: rad = $urandom;
      default: rad = $urandom_range(64, 1 << 17);
    endcase
    write_reg(REG_RADIUS, rad | ($urandom & 32'h8000_0000));
    write_reg(REG_SWAP, $urandom);
    write_reg(REG_COM_ERR, $urandom);
    write_reg(REG_REF_ERR, $urandom);
    write_reg(REG_COM_RANK, $urandom);
    write_reg(REG_REF_RANK, $urandom);
  endtask

  function automatic logic [15:0] pick_err();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return 16'd0;
    if (roll < 7) return 16'($urandom_range(1, 1024));
    return 16'($urandom);
  endfunction

  // sorted run of loads on the current primary axis
  task automatic load_sorted(int k, int step_max);
    int prim, secv;
    prim = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    for (int i = 0; i < k; i++) begin
      prim += $urandom_range(0, step_max);
      secv = $signed($urandom_range(0, 1 << 14)) - (1 << 13);
      if (sb.cfg.swap_axes) send_word(CMD_LOAD, secv, prim, 16'($urandom), pick_err(), 0);
      else send_word(CMD_LOAD, prim, secv, 16'($urandom), pick_err(), 0);
    end
  endtask

  // match near a loaded entry, or anywhere
  task automatic match_one(logic [9:0] obj);
    int j, span, dx, dy;
    if (ref_x.size() == 0 || $urandom_range(0, 9) == 0) begin
      send_word(CMD_MATCH, $urandom, $urandom, 16'($urandom), pick_err(), obj);
    end else begin
      j = $urandom_range(0, ref_x.size() - 1);
      span = sb.cfg.radius > (1 << 16) ? (1 << 16) : int'(sb.cfg.radius);
      dx = $signed($urandom_range(0, 2 * span)) - span;
      dy = $signed($urandom_range(0, 2 * span)) - span;
      send_word(CMD_MATCH, ref_x[j] + dx, ref_y[j] + dy, 16'($urandom), pick_err(), obj);
    end
  endtask

  initial begin
    int phase, k, m;
    logic [9:0] pool;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ownership, displacement, ties, extremes
    send_word(CMD_LOAD, 0, 0, 16'sh7FFF, 16'hFFFF, 0);
    send_word(CMD_LOAD, 8192, 0, 16'sh8000, 16'd0, 0);
    send_word(CMD_LOAD, 10240, 0, 16'sd256, 16'd256, 0);
    send_word(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'd1, 0);
    send_word(CMD_MATCH, 100, 0, 0, 0, 10'd1);
    send_word(CMD_MATCH, 2000, 0, 0, 0, 10'd2);
    send_word(CMD_MATCH, 50, 0, 0, 0, 10'd3);
    send_word(CMD_MATCH, 50, 0, 0, 0, 10'd3);
    send_word(CMD_MATCH, 4096, 0, 0, 0, 10'd4);
    send_word(CMD_MATCH, 9216, 0, 0, 0, 10'd5);
    send_word(CMD_MATCH, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000, 16'hFFFF, 10'h3FF);
    send_word(CMD_MATCH, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 0, 10'h000);
    send_word(CMD_BAD, $urandom, $urandom, 16'($urandom), 16'($urandom), 10'($urandom));
    send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_word(CMD_MATCH, 0, 0, 0, 0, 10'd6);

    // random phases
    phase = 0;
    while (words_sent < 600) begin
      if (phase == 0 || $urandom_range(0, 3) != 0) random_config();
      if ($urandom_range(0, 9) < 7) send_word(CMD_CLEAR, $urandom, $urandom, 0, 0, 0);
      k = $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < k; i++)
          send_word(CMD_LOAD, $urandom, $urandom, 16'($urandom), pick_err(), 10'($urandom));
      end else begin
        load_sorted(k, $urandom_range(0, 1) ? 8192 : 1 << 16);
      end
      if (phase == 3) hold_left = 500;
      m = phase == 3 ? 40 : $urandom_range(4, 20);
      pool = 10'($urandom);
      for (int i = 0; i < m; i++) begin
        if ($urandom_range(0, 19) == 0) send_word(CMD_BAD, $urandom, $urandom, 0, 0, 0);
        if ($urandom_range(0, 2) == 0) match_one(10'(pool + $urandom_range(0, 3)));
        else match_one(10'($urandom));
      end
      phase++;
    end

    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/lcm_pkg.sv
rtl/lcm_front.sv
rtl/lcm_div.sv
rtl/lcm_engine.sv
rtl/likelihood_cross_match_unit.sv
test/tb.sv
